// File: hw/rtl/odo_pkg.sv
// Shared types, constants and tables for the two-wheel odometry block.
// Used by every module under hw/rtl; it depends on nothing else.
`timescale 1ns / 1ps

package odo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_DEPTH       = 24;

  // Fixed-point widths of the datapath.
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 64;
  localparam int POS_W   = 40;
  localparam int TRIG_W  = 26;

  localparam logic signed [MUL_B_W-1:0] TWO_PI_Q16 = 26'sd411775;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [POS_W-1:0] POS_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 40'sh80_0000_0000;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RADIUS_A     = 3'd0;
  localparam logic [2:0] CFG_RADIUS_B     = 3'd1;
  localparam logic [2:0] CFG_COS_A        = 3'd2;
  localparam logic [2:0] CFG_SIN_A        = 3'd3;
  localparam logic [2:0] CFG_COS_B        = 3'd4;
  localparam logic [2:0] CFG_SIN_B        = 3'd5;
  localparam logic [2:0] CFG_INV_SIN_DIFF = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } odo_state_t;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB,
    MAC_HOLD
  } mac_mode_t;

  // One operation for the shared multiply-accumulate unit.
  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
    logic                      shft;
    mac_mode_t                 mode;
  } mac_op_t;

  typedef struct packed {
    logic issue;
    logic apply;
  } mac_ctl_t;

  // Arctangent of 2^-i at 2^32 per turn.
  function automatic logic [29:0] atan_q32(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/odo_if.sv
// Channel interfaces of the odometry block: input, result and configuration.
// The field widths are written out here; nothing from odo_pkg is used.
`timescale 1ns / 1ps

interface odo_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] heading;
  logic signed [31:0] dist_a;
  logic signed [31:0] dist_b;
  logic signed [39:0] set_x;
  logic signed [39:0] set_y;
  modport source (output valid, command, heading, dist_a, dist_b, set_x, set_y,
                  input ready);
  modport sink (input valid, command, heading, dist_a, dist_b, set_x, set_y,
                output ready);
endinterface

interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] pos_x;
  logic signed [39:0] pos_y;
  logic               saturated;
  modport source (output valid, pos_x, pos_y, saturated, input ready);
  modport sink (input valid, pos_x, pos_y, saturated, output ready);
endinterface

interface odo_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/odo_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on odo_pkg for the operation struct and widths.
`timescale 1ns / 1ps

module odo_mac (
  input  logic                            clk,
  input  odo_pkg::mac_ctl_t               ctl,
  input  odo_pkg::mac_op_t                op,
  output logic signed [odo_pkg::ACC_W-1:0] acc
);
  import odo_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     shft;
  mac_mode_t                mode;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  acc_next;

  // Product stage.
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod <= op.a * op.b;
      shft <= op.shft;
      mode <= op.mode;
    end
  end

  // High partial products enter the sum shifted up by twenty bits.
  always_comb begin
    if (shft) begin
      addend = {prod[ACC_W-21:0], 20'b0};
    end else begin
      addend = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  always_comb begin
    case (mode)
      MAC_LOAD: acc_next = addend;
      MAC_ADD:  acc_next = acc + addend;
      MAC_SUB:  acc_next = acc - addend;
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      acc <= acc_next;
    end
  end

endmodule

// File: hw/rtl/odo_cordic.sv
// Iterative CORDIC for the cosine and sine of a binary angle, one step a cycle.
// Depends on odo_pkg for the arctangent table and the gain constant.
`timescale 1ns / 1ps

module odo_cordic #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [15:0]                angle,
  output logic                              done,
  output logic signed [odo_pkg::TRIG_W-1:0] cos_q24,
  output logic signed [odo_pkg::TRIG_W-1:0] sin_q24
);
  import odo_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

  logic               busy;
  logic [CNT_W-1:0]   step;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic               flip;
  logic signed [33:0] z0;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] ang;
  logic signed [33:0] xo;
  logic signed [33:0] yo;
  logic signed [33:0] xr;
  logic signed [33:0] yr;

  assign z0  = {{2{angle[15]}}, angle, 16'b0};
  assign xs  = x >>> step;
  assign ys  = y >>> step;
  assign ang = {4'b0, atan_q32(5'(step))};

  // Fold the angle to a quarter turn, then rotate towards zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
      x    <= CORDIC_GAIN_Q30;
      y    <= '0;
      if (z0 > 34'sd1073741824) begin
        z    <= z0 - 34'sd2147483648;
        flip <= 1'b1;
      end else if (z0 < -34'sd1073741824) begin
        z    <= z0 + 34'sd2147483648;
        flip <= 1'b1;
      end else begin
        z    <= z0;
        flip <= 1'b0;
      end
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end
      step <= step + 1'b1;
      if (step == CNT_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Undo the fold and round to Q24.
  assign xo = flip ? -x : x;
  assign yo = flip ? -y : y;
  assign xr = (xo + 34'sd32) >>> 6;
  assign yr = (yo + 34'sd32) >>> 6;
  assign cos_q24 = xr[TRIG_W-1:0];
  assign sin_q24 = yr[TRIG_W-1:0];

endmodule

// File: hw/rtl/two_wheel_odometry_update.sv
// Top level of the two-wheel odometry block: sequencer, state and registers.
// Depends on odo_pkg, odo_if, odo_mac and odo_cordic.
//
// Channels: din carries one word per item (command, heading, wheel distances,
// pose for set pose); dout carries one word per item (position, saturation
// flag); cfg writes a register index and data and is always ready.
// An update word runs twenty multiply-accumulate steps on the one shared
// multiplier, each an issue then an apply, then one step to capture the
// last product, and the final clamp into the result register. The CORDIC
// runs alongside; with the default step count it is finished before the
// rotation steps need it, and otherwise the sequence waits at the first
// rotation step until it is done. A set-pose word goes straight to the
// final state, where its result is registered.
// The block takes one word at a time; din.ready is high only when idle.
// The result register parts the two sides: a new word is taken while a
// result waits, and a finished word waits in the last state while dout is
// stalled.
// Reset (rst, synchronous) clears the pose, the stored heading and
// distances and the registers to their defaults; no result is pending.
`timescale 1ns / 1ps

module two_wheel_odometry_update #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input logic      clk,
  input logic      rst,
  odo_in_if.sink   din,
  odo_out_if.source dout,
  odo_cfg_if.sink  cfg
);
  import odo_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'd20;
  localparam logic [4:0] ROT_STEP  = 5'd12;

  odo_state_t state;
  odo_state_t state_next;

  logic signed [23:0] radius_a;
  logic signed [23:0] radius_b;
  logic signed [15:0] cos_a;
  logic signed [15:0] sin_a;
  logic signed [15:0] cos_b;
  logic signed [15:0] sin_b;
  logic signed [15:0] inv_sin_diff;

  logic signed [15:0]     last_heading;
  logic signed [31:0]     last_dist_a;
  logic signed [31:0]     last_dist_b;
  logic signed [POS_W-1:0] cur_x;
  logic signed [POS_W-1:0] cur_y;

  logic                    cmd;
  logic signed [15:0]      hd;
  logic signed [31:0]      da;
  logic signed [31:0]      db;
  logic signed [POS_W-1:0] set_x;
  logic signed [POS_W-1:0] set_y;

  logic [4:0]              step;
  logic                    ph;
  logic [19:0]             tmp_lo;
  logic signed [33:0]      sa;
  logic signed [33:0]      sb;
  logic signed [POS_W-1:0] lx;
  logic signed [POS_W-1:0] ly;
  logic signed [POS_W-1:0] dx;
  logic signed [POS_W-1:0] dy;

  logic                    ov;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic                    out_sat;

  logic                    accept;
  logic                    slot_free;
  logic                    rot_wait;
  logic                    advance;
  logic                    finish;
  logic signed [15:0]      dh;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_r12;
  logic signed [ACC_W-1:0] acc_r15;
  logic signed [ACC_W-1:0] acc_r24;
  logic signed [ACC_W-1:0] acc_r32;
  logic signed [31:0]      diff_a;
  logic signed [31:0]      diff_b;
  logic signed [33:0]      s_new;
  logic signed [MUL_A_W-1:0] lx_hi;
  logic signed [MUL_A_W-1:0] lx_lo;
  logic signed [MUL_A_W-1:0] ly_hi;
  logic signed [MUL_A_W-1:0] ly_lo;
  logic signed [MUL_B_W-1:0] c_op;
  logic signed [MUL_B_W-1:0] s_op;
  logic signed [POS_W:0]   sum_x;
  logic signed [POS_W:0]   sum_y;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_y;
  logic                    sat_x;
  logic                    sat_y;

  mac_op_t                 op;
  mac_ctl_t                ctl;
  logic                    cor_done;
  logic signed [TRIG_W-1:0] cos_q24;
  logic signed [TRIG_W-1:0] sin_q24;

  assign accept    = din.valid && din.ready;
  assign slot_free = !ov || dout.ready;
  assign rot_wait  = (step == ROT_STEP) && !cor_done;
  assign advance   = (state == ST_RUN) && !ph && !rot_wait;
  assign finish    = (state == ST_FINISH) && slot_free;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_a     <= '0;
      radius_b     <= '0;
      cos_a        <= 16'sd32767;
      sin_a        <= '0;
      cos_b        <= '0;
      sin_b        <= 16'sd32767;
      inv_sin_diff <= -16'sd4096;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_RADIUS_A:     radius_a     <= cfg.data;
        CFG_RADIUS_B:     radius_b     <= cfg.data;
        CFG_COS_A:        cos_a        <= cfg.data[15:0];
        CFG_SIN_A:        sin_a        <= cfg.data[15:0];
        CFG_COS_B:        cos_b        <= cfg.data[15:0];
        CFG_SIN_B:        sin_b        <= cfg.data[15:0];
        CFG_INV_SIN_DIFF: inv_sin_diff <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = din.command ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance && (step == LAST_STEP)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs of the state machine.
  always_comb begin
    din.ready = (state == ST_IDLE);
    ctl.issue = advance && (step != LAST_STEP);
    ctl.apply = (state == ST_RUN) && ph;
  end

  // Rounded views of the accumulator and the wrapped input differences.
  assign dh      = hd - last_heading;
  assign diff_a  = da - last_dist_a;
  assign diff_b  = db - last_dist_b;
  assign acc_r12 = (acc + 64'sd2048) >>> 12;
  assign acc_r15 = (acc + 64'sd16384) >>> 15;
  assign acc_r24 = (acc + 64'sd8388608) >>> 24;
  assign acc_r32 = (acc + 64'sd2147483648) >>> 32;
  assign s_new   = (step == 5'd3) ? ({{2{diff_a[31]}}, diff_a} - acc_r32[33:0])
                                  : ({{2{diff_b[31]}}, diff_b} - acc_r32[33:0]);
  assign lx_hi   = {{(MUL_A_W-20){lx[39]}}, lx[39:20]};
  assign lx_lo   = {{(MUL_A_W-20){1'b0}}, lx[19:0]};
  assign ly_hi   = {{(MUL_A_W-20){ly[39]}}, ly[39:20]};
  assign ly_lo   = {{(MUL_A_W-20){1'b0}}, ly[19:0]};
  assign c_op    = cos_q24;
  assign s_op    = sin_q24;

  // Operand selection for each step of the sequence.
  always_comb begin
    op.a    = '0;
    op.b    = '0;
    op.shft = 1'b0;
    op.mode = MAC_HOLD;
    case (step)
      5'd0, 5'd3: begin
        op.a    = (step == 5'd0) ? MUL_A_W'(radius_a) : MUL_A_W'(radius_b);
        op.b    = MUL_B_W'(dh);
        op.mode = MAC_LOAD;
      end
      5'd1, 5'd4: begin
        op.a    = {{(MUL_A_W-20){acc[39]}}, acc[39:20]};
        op.b    = TWO_PI_Q16;
        op.shft = 1'b1;
        op.mode = MAC_LOAD;
      end
      5'd2, 5'd5: begin
        op.a    = {{(MUL_A_W-20){1'b0}}, tmp_lo};
        op.b    = TWO_PI_Q16;
        op.mode = MAC_ADD;
      end
      5'd6: begin
        op.a    = MUL_A_W'(sa);
        op.b    = MUL_B_W'(cos_b);
        op.mode = MAC_LOAD;
      end
      5'd7: begin
        op.a    = MUL_A_W'(sb);
        op.b    = MUL_B_W'(cos_a);
        op.mode = MAC_SUB;
      end
      5'd8, 5'd11: begin
        op.a    = acc_r15[MUL_A_W-1:0];
        op.b    = MUL_B_W'(inv_sin_diff);
        op.mode = MAC_LOAD;
      end
      5'd9: begin
        op.a    = MUL_A_W'(sb);
        op.b    = MUL_B_W'(sin_a);
        op.mode = MAC_LOAD;
      end
      5'd10: begin
        op.a    = MUL_A_W'(sa);
        op.b    = MUL_B_W'(sin_b);
        op.mode = MAC_SUB;
      end
      5'd12: begin
        op.a = lx_hi; op.b = c_op; op.shft = 1'b1; op.mode = MAC_LOAD;
      end
      5'd13: begin
        op.a = lx_lo; op.b = c_op; op.mode = MAC_ADD;
      end
      5'd14: begin
        op.a = ly_hi; op.b = s_op; op.shft = 1'b1; op.mode = MAC_SUB;
      end
      5'd15: begin
        op.a = ly_lo; op.b = s_op; op.mode = MAC_SUB;
      end
      5'd16: begin
        op.a = lx_hi; op.b = s_op; op.shft = 1'b1; op.mode = MAC_LOAD;
      end
      5'd17: begin
        op.a = lx_lo; op.b = s_op; op.mode = MAC_ADD;
      end
      5'd18: begin
        op.a = ly_hi; op.b = c_op; op.shft = 1'b1; op.mode = MAC_ADD;
      end
      5'd19: begin
        op.a = ly_lo; op.b = c_op; op.mode = MAC_ADD;
      end
      default: ;
    endcase
  end

  // Sequencer: capture intermediate results as the accumulator produces them.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      ph   <= 1'b0;
    end else if (accept) begin
      step <= '0;
      ph   <= 1'b0;
    end else if (state == ST_RUN) begin
      if (ph) begin
        ph   <= 1'b0;
        step <= step + 1'b1;
      end else if (!rot_wait) begin
        ph <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      case (step)
        5'd1, 5'd4: tmp_lo <= acc[19:0];
        5'd3:       sa     <= s_new;
        5'd6:       sb     <= s_new;
        5'd9:       lx     <= acc_r12[POS_W-1:0];
        5'd12:      ly     <= acc_r12[POS_W-1:0];
        5'd16:      dx     <= acc_r24[POS_W-1:0];
        5'd20:      dy     <= acc_r24[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= din.command;
      hd    <= din.heading;
      da    <= din.dist_a;
      db    <= din.dist_b;
      set_x <= din.set_x;
      set_y <= din.set_y;
    end
  end

  // Saturating position update.
  assign sum_x = {cur_x[POS_W-1], cur_x} + {dx[POS_W-1], dx};
  assign sum_y = {cur_y[POS_W-1], cur_y} + {dy[POS_W-1], dy};
  assign sat_x = sum_x[POS_W] != sum_x[POS_W-1];
  assign sat_y = sum_y[POS_W] != sum_y[POS_W-1];
  assign new_x = sat_x ? (sum_x[POS_W] ? POS_MIN : POS_MAX) : sum_x[POS_W-1:0];
  assign new_y = sat_y ? (sum_y[POS_W] ? POS_MIN : POS_MAX) : sum_y[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_heading <= '0;
      last_dist_a  <= '0;
      last_dist_b  <= '0;
      cur_x        <= '0;
      cur_y        <= '0;
    end else if (finish) begin
      last_heading <= hd;
      if (cmd) begin
        cur_x       <= set_x;
        cur_y       <= set_y;
        last_dist_a <= '0;
        last_dist_b <= '0;
      end else begin
        cur_x       <= new_x;
        cur_y       <= new_y;
        last_dist_a <= da;
        last_dist_b <= db;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (finish) begin
      ov <= 1'b1;
    end else if (dout.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_x   <= cmd ? set_x : new_x;
      out_y   <= cmd ? set_y : new_y;
      out_sat <= !cmd && (sat_x || sat_y);
    end
  end

  assign dout.valid     = ov;
  assign dout.pos_x     = out_x;
  assign dout.pos_y     = out_y;
  assign dout.saturated = out_sat;

  odo_mac u_mac (
    .clk (clk),
    .ctl (ctl),
    .op  (op),
    .acc (acc)
  );

  odo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && !din.command),
    .angle   (din.heading),
    .done    (cor_done),
    .cos_q24 (cos_q24),
    .sin_q24 (sin_q24)
  );

endmodule

// File: hw/rtl/odo_checker.sv
// Port-level checks of the odometry block, bound to its top level.
// Depends on odo_pkg for the position limits.
`timescale 1ns / 1ps

module odo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [39:0] pos_x,
  input logic signed [39:0] pos_y,
  input logic               saturated
);
  import odo_pkg::*;

  // Only one word is processed at a time: the input closes after an acceptance.
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // No result is pending just after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pos_x) && $stable(pos_y)))
    else $error("stalled result changed");

  // A clamped result sits on a limit of the position range.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (pos_x == POS_MAX || pos_x == POS_MIN || pos_y == POS_MAX || pos_y == POS_MIN))
    else $error("saturation flag without a clamped coordinate");

endmodule

bind two_wheel_odometry_update odo_checker u_odo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .pos_x     (dout.pos_x),
  .pos_y     (dout.pos_y),
  .saturated (dout.saturated)
);
